### hw/rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Clocked concurrent assertion helpers shared by the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check prop at every clk edge outside reset
`define MFAD_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// check that a condition implies another in the same cycle
`define MFAD_IMPLY(lbl, cond, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) else $error(msg);

`endif

### hw/rtl/mfad_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfad_pkg
// Types and constants for the mixed fraction adder with decimal text output.
// ----------------------------------------------------------------------------
package mfad_pkg;

  localparam int MAX_LENGTH_DEF = 32;
  localparam int CFG_W          = 6;
  localparam logic [CFG_W-1:0] LEN_RESET = 6'd15;

  localparam int MUL_W      = 32;
  localparam int DEN_W      = 30;
  localparam int ACC_W      = 49;
  localparam int MAG_W      = 48;
  localparam int BCD_DIGITS = 16;
  localparam int FRAC_W     = 34;

  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_NUL   = 8'h00;

  typedef struct packed {
    logic signed [15:0] whole_a;
    logic signed [15:0] numer_a;
    logic signed [15:0] denom_a;
    logic signed [15:0] whole_b;
    logic signed [15:0] numer_b;
    logic signed [15:0] denom_b;
  } in_item_t;

  typedef struct packed {
    logic [7:0] text_char;
    logic       last_char;
    logic       ok;
  } out_item_t;

endpackage

### hw/rtl/mfad_mul.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfad_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
module mfad_mul
  import mfad_pkg::*;
(
  input  logic                        clk,
  input  logic signed [MUL_W-1:0]     a,
  input  logic signed [MUL_W-1:0]     b,
  output logic signed [2*MUL_W-1:0]   p
);

  always_ff @(posedge clk) begin
    p <= a * b;
  end

endmodule

### hw/rtl/mixed_fraction_add_to_decimal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mixed_fraction_add_to_decimal
// Adds two mixed numbers and streams the sum as ASCII decimal text, with the fraction cut to fit the buffer.
// Steps: products on one shared multiplier, bit-serial division with
// binary to BCD, a check, then one character per cycle for sign, integer
// digits and '.', and compare-and-subtract steps before each fraction digit.
// Bad input gives its single failure result in the cycle after the accept
// edge. One item at a time, busy high until its last character; results
// cannot be stalled.
// Synchronous active-low reset clears control state and sets length to 15.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module mixed_fraction_add_to_decimal
  import mfad_pkg::*;
#(
  parameter int MAX_LENGTH = MAX_LENGTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  output logic             busy,
  input  in_item_t         in_data,
  output logic             out_valid,
  output out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int CW = $clog2(MAX_LENGTH + 1);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b000000001,
    S_MUL   = 9'b000000010,
    S_DIV   = 9'b000000100,
    S_CHK   = 9'b000001000,
    S_INT   = 9'b000010000,
    S_DOT   = 9'b000100000,
    S_FDIG  = 9'b001000000,
    S_FEMIT = 9'b010000000,
    S_SPARE = 9'b100000000
  } state_t;

  state_t                 state_r;
  logic [CFG_W-1:0]       len_r;
  logic signed [15:0]     ca_r, cb_r, na_r, nb_r, da_r, db_r;
  logic [2:0]             step_r;
  logic [5:0]             bit_r;
  logic [DEN_W-1:0]       den_r;
  logic signed [ACC_W-1:0] acc_r;
  logic [MAG_W-1:0]       mag_r;
  logic                   neg_r;
  logic [DEN_W-1:0]       rem_r;
  logic [4*BCD_DIGITS-1:0] bcd_r;
  logic [3:0]             dig_r;
  logic                   sign_pend_r;
  logic                   fracgo_r;
  logic [CW-1:0]          cnt_r;
  logic [FRAC_W-1:0]      frac_r;
  logic [3:0]             fd_r;
  logic                   out_valid_r;
  out_item_t              out_r;

  logic signed [MUL_W-1:0]   mul_a, mul_b;
  logic signed [2*MUL_W-1:0] mul_p;

  mfad_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .p(mul_p));

  // effective buffer size and capacity
  logic [6:0] eff7, cap7;
  always_comb begin
    eff7 = ({1'b0, len_r} > 7'(MAX_LENGTH)) ? 7'(MAX_LENGTH) : {1'b0, len_r};
    cap7 = eff7 - 7'd1;
  end

  // input check
  logic signed [15:0] na_adj, nb_adj;
  logic               in_bad;
  always_comb begin
    na_adj = (in_data.whole_a < 0 && in_data.numer_a > 0) ? -in_data.numer_a
                                                          : in_data.numer_a;
    nb_adj = (in_data.whole_b < 0 && in_data.numer_b > 0) ? -in_data.numer_b
                                                          : in_data.numer_b;
    in_bad = (in_data.denom_a <= 0) || (in_data.denom_b <= 0) ||
             (in_data.whole_a > 0 && na_adj < 0) ||
             (in_data.whole_b > 0 && nb_adj < 0) || (eff7 < 7'd2);
  end

  // multiplier operand select
  logic signed [16:0] csum;
  always_comb begin
    csum  = {ca_r[15], ca_r} + {cb_r[15], cb_r};
    mul_a = {{16{da_r[15]}}, da_r};
    mul_b = {{16{db_r[15]}}, db_r};
    case (step_r)
      3'd1: begin
        mul_a = {{16{na_r[15]}}, na_r};
        mul_b = {{16{db_r[15]}}, db_r};
      end
      3'd2: begin
        mul_a = {{16{nb_r[15]}}, nb_r};
        mul_b = {{16{da_r[15]}}, da_r};
      end
      3'd3: begin
        mul_a = {{15{csum[16]}}, csum};
        mul_b = {2'b00, den_r};
      end
      default: begin
        mul_a = {{16{da_r[15]}}, da_r};
        mul_b = {{16{db_r[15]}}, db_r};
      end
    endcase
  end

  // sum and magnitude
  logic signed [ACC_W-1:0] total;
  logic [MAG_W-1:0]        mag_new;
  always_comb begin
    total   = acc_r + mul_p[ACC_W-1:0];
    mag_new = total[ACC_W-1] ? MAG_W'(-total) : MAG_W'(total);
  end

  // division step and BCD shift
  logic [DEN_W:0]          rsh;
  logic                    qbit;
  logic [DEN_W:0]          rsub;
  logic [4*BCD_DIGITS-1:0] bcd_adj;
  always_comb begin
    rsh  = {rem_r, mag_r[MAG_W-1]};
    qbit = rsh >= {1'b0, den_r};
    rsub = rsh - {1'b0, den_r};
    for (int i = 0; i < BCD_DIGITS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_r[4*i +: 4] >= 4'd5) ? bcd_r[4*i +: 4] + 4'd3
                                                    : bcd_r[4*i +: 4];
    end
  end

  // digit count
  logic [4:0] nd;
  logic [6:0] tot7;
  always_comb begin
    nd = 5'd1;
    for (int i = 0; i < BCD_DIGITS; i++) begin
      if (bcd_r[4*i +: 4] != 4'd0) nd = 5'(i + 1);
    end
    tot7 = 7'(nd) + 7'(neg_r);
  end

  // fraction step
  logic [FRAC_W-1:0] dsh, rem10, frac10;
  logic              fge, flast;
  always_comb begin
    dsh    = {{(FRAC_W-DEN_W){1'b0}}, den_r} << step_r;
    fge    = frac_r >= dsh;
    rem10  = {1'b0, rem_r[DEN_W-1:0], 3'b000} + {3'b000, rem_r[DEN_W-1:0], 1'b0};
    frac10 = {1'b0, frac_r[DEN_W-1:0], 3'b000} + {3'b000, frac_r[DEN_W-1:0], 1'b0};
    flast  = (frac_r == '0) || (7'(cnt_r) + 7'd1 == cap7);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      len_r       <= LEN_RESET;
      out_valid_r <= 1'b0;
      step_r      <= '0;
      bit_r       <= '0;
      sign_pend_r <= 1'b0;
      fracgo_r    <= 1'b0;
      cnt_r       <= '0;
    end else begin
      out_valid_r <= 1'b0;
      if (cfg_we) len_r <= cfg_wdata;
      case (state_r)
        S_IDLE: begin
          if (start) begin
            if (in_bad) begin
              out_valid_r     <= 1'b1;
              out_r.text_char <= CH_NUL;
              out_r.last_char <= 1'b1;
              out_r.ok        <= 1'b0;
            end else begin
              ca_r    <= in_data.whole_a;
              cb_r    <= in_data.whole_b;
              na_r    <= na_adj;
              nb_r    <= nb_adj;
              da_r    <= in_data.denom_a;
              db_r    <= in_data.denom_b;
              step_r  <= 3'd0;
              state_r <= S_MUL;
            end
          end
        end
        S_MUL: begin
          step_r <= step_r + 3'd1;
          case (step_r)
            3'd1: den_r <= mul_p[DEN_W-1:0];
            3'd2: acc_r <= mul_p[ACC_W-1:0];
            3'd3: acc_r <= total;
            3'd4: begin
              mag_r   <= mag_new;
              neg_r   <= total[ACC_W-1];
              rem_r   <= '0;
              bcd_r   <= '0;
              bit_r   <= '0;
              state_r <= S_DIV;
            end
            default: ;
          endcase
        end
        S_DIV: begin
          rem_r <= qbit ? rsub[DEN_W-1:0] : rsh[DEN_W-1:0];
          bcd_r <= {bcd_adj[4*BCD_DIGITS-2:0], qbit};
          mag_r <= {mag_r[MAG_W-2:0], 1'b0};
          bit_r <= bit_r + 6'd1;
          if (bit_r == 6'(MAG_W - 1)) state_r <= S_CHK;
        end
        S_CHK: begin
          if (tot7 > cap7) begin
            out_valid_r     <= 1'b1;
            out_r.text_char <= CH_NUL;
            out_r.last_char <= 1'b1;
            out_r.ok        <= 1'b0;
            state_r         <= S_IDLE;
          end else begin
            sign_pend_r <= neg_r;
            dig_r       <= 4'(nd - 5'd1);
            fracgo_r    <= (rem_r != '0) && (tot7 + 7'd2 <= cap7);
            cnt_r       <= CW'(tot7);
            state_r     <= S_INT;
          end
        end
        S_INT: begin
          out_valid_r <= 1'b1;
          out_r.ok    <= 1'b1;
          if (sign_pend_r) begin
            out_r.text_char <= CH_MINUS;
            out_r.last_char <= 1'b0;
            sign_pend_r     <= 1'b0;
          end else begin
            out_r.text_char <= CH_ZERO + {4'b0000, bcd_r[{dig_r, 2'b00} +: 4]};
            out_r.last_char <= (dig_r == 4'd0) && !fracgo_r;
            dig_r           <= dig_r - 4'd1;
            if (dig_r == 4'd0) state_r <= fracgo_r ? S_DOT : S_IDLE;
          end
        end
        S_DOT: begin
          out_valid_r     <= 1'b1;
          out_r.ok        <= 1'b1;
          out_r.text_char <= CH_DOT;
          out_r.last_char <= 1'b0;
          cnt_r           <= cnt_r + CW'(1);
          frac_r          <= rem10;
          fd_r            <= '0;
          step_r          <= 3'd3;
          state_r         <= S_FDIG;
        end
        S_FDIG: begin
          if (fge) frac_r <= frac_r - dsh;
          fd_r[step_r[1:0]] <= fge;
          step_r <= step_r - 3'd1;
          if (step_r == 3'd0) state_r <= S_FEMIT;
        end
        S_FEMIT: begin
          out_valid_r     <= 1'b1;
          out_r.ok        <= 1'b1;
          out_r.text_char <= CH_ZERO + {4'b0000, fd_r};
          out_r.last_char <= flast;
          cnt_r           <= cnt_r + CW'(1);
          if (flast) begin
            state_r <= S_IDLE;
          end else begin
            frac_r  <= frac10;
            fd_r    <= '0;
            step_r  <= 3'd3;
            state_r <= S_FDIG;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign busy      = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  `MFAD_ASSERT(a_done_last, $fell(busy) |-> (out_valid && out_data.last_char), "busy fell without last character")
  `MFAD_IMPLY(a_fail_form, out_valid && !out_data.ok, out_data.last_char && out_data.text_char == CH_NUL, "malformed failure result")
  `MFAD_ASSERT(a_out_src, out_valid |-> ($past(busy) || $past(start)), "result without a transfer in flight")

endmodule

### tb/mfad_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mfad_checker
// Watches the item and text channels of the mixed fraction adder, computes
// the expected decimal text of each accepted sum and compares every character.
// ----------------------------------------------------------------------------
module mfad_checker
  import mfad_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             busy,
  input  in_item_t         in_data,
  input  logic             out_valid,
  input  out_item_t        out_data,
  input  logic             cfg_we,
  input  logic [CFG_W-1:0] cfg_wdata,
  output int               fail_count,
  output int               pending_chars,
  output int               chars_seen
);

  out_item_t  text_q[$];
  logic [5:0] buf_len;

  function automatic out_item_t mk(logic [7:0] c, logic l, logic k);
    out_item_t r;
    r.text_char = c;
    r.last_char = l;
    r.ok        = k;
    return r;
  endfunction

  task automatic predict_text(in_item_t it);
    longint wa, na, da, wb, nb, db, total, den, mag, ip, rem, cap, len;
    logic [7:0] digs[$];
    logic [7:0] txt[$];
    bit neg;
    wa = it.whole_a; na = it.numer_a; da = it.denom_a;
    wb = it.whole_b; nb = it.numer_b; db = it.denom_b;
    len = buf_len;
    if (len > MAX_LENGTH_DEF) len = MAX_LENGTH_DEF;
    if (len < 2 || da <= 0 || db <= 0) begin
      text_q.push_back(mk(CH_NUL, 1'b1, 1'b0));
      return;
    end
    cap = len - 1;
    if (wa < 0 && na > 0) na = -na;
    if (wb < 0 && nb > 0) nb = -nb;
    if ((wa > 0 && na < 0) || (wb > 0 && nb < 0)) begin
      text_q.push_back(mk(CH_NUL, 1'b1, 1'b0));
      return;
    end
    den = da * db;
    total = (wa + wb) * den + na * db + nb * da;
    neg = total < 0;
    mag = neg ? -total : total;
    ip = mag / den;
    rem = mag % den;
    do begin
      digs.push_front(CH_ZERO + 8'(ip % 10));
      ip = ip / 10;
    end while (ip != 0);
    if (digs.size() + (neg ? 1 : 0) > cap) begin
      text_q.push_back(mk(CH_NUL, 1'b1, 1'b0));
      return;
    end
    if (neg) txt.push_back(CH_MINUS);
    foreach (digs[i]) txt.push_back(digs[i]);
    if (rem != 0 && txt.size() + 2 <= cap) begin
      txt.push_back(CH_DOT);
      while (rem != 0 && txt.size() < cap) begin
        rem = rem * 10;
        txt.push_back(CH_ZERO + 8'(rem / den));
        rem = rem % den;
      end
    end
    foreach (txt[i]) text_q.push_back(mk(txt[i], i == txt.size() - 1, 1'b1));
  endtask

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      buf_len <= LEN_RESET;
      fail_count <= 0;
      chars_seen <= 0;
      text_q.delete();
    end else begin
      if (out_valid) begin
        chars_seen <= chars_seen + 1;
        if (text_q.size() == 0) begin
          $display("%0t: unexpected transfer, actual %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          if (out_data !== text_q[0]) begin
            $display("%0t: mismatch, expected char %h last %b ok %b, actual %h %b %b",
                     $time, text_q[0].text_char, text_q[0].last_char, text_q[0].ok,
                     out_data.text_char, out_data.last_char, out_data.ok);
            fail_count <= fail_count + 1;
          end
          void'(text_q.pop_front());
        end
      end
      if (start && !busy) predict_text(in_data);
      if (cfg_we) buf_len <= cfg_wdata;
    end
  end

  assign pending_chars = text_q.size();

endmodule

### tb/tb_mixed_fraction_add_to_decimal.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_mixed_fraction_add_to_decimal
// Drives directed and random mixed number pairs through several buffer
// lengths with random gaps; a checker compares every emitted character.
// ----------------------------------------------------------------------------
module tb_mixed_fraction_add_to_decimal;
  import mfad_pkg::*;

  localparam int WATCHDOG = 20000;

  logic             clk = 1'b0;
  logic             rst_n = 1'b0;
  logic             start = 1'b0;
  logic             busy;
  in_item_t         in_data = '0;
  logic             out_valid;
  out_item_t        out_data;
  logic             cfg_we = 1'b0;
  logic [CFG_W-1:0] cfg_wdata = '0;
  int               fail_count, pending_chars, chars_seen;
  int               idle_cycles = 0;
  int               items_sent = 0;

  always #5 clk = ~clk;

  mixed_fraction_add_to_decimal dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  mfad_checker chk (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_valid(out_valid), .out_data(out_data), .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata), .fail_count(fail_count),
    .pending_chars(pending_chars), .chars_seen(chars_seen)
  );

  always @(posedge clk) begin
    if ((start && !busy) || out_valid) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG) begin
      $display("watchdog expired");
      $display("== FAIL ==");
      $finish;
    end
  end

  // drop start only for a real gap, so back-to-back items keep it high
  task automatic gap();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80) :
        ($urandom_range(0, 2) == 0 ? 0 : $urandom_range(1, 4));
    if (n != 0) begin
      start <= 1'b0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic send(in_item_t it);
    start <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    items_sent++;
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (busy || pending_chars != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_len(logic [CFG_W-1:0] v);
    drain();
    cfg_we <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic in_item_t mk(int wa, int na, int da, int wb, int nb, int db);
    in_item_t r;
    r.whole_a = 16'(wa); r.numer_a = 16'(na); r.denom_a = 16'(da);
    r.whole_b = 16'(wb); r.numer_b = 16'(nb); r.denom_b = 16'(db);
    return r;
  endfunction

  function automatic logic [15:0] rnd_field(int kind);
    case (kind)
      0: return 16'($urandom);
      1: return 16'($urandom_range(0, 20));
      default: return 16'(-$urandom_range(0, 20));
    endcase
  endfunction

  function automatic in_item_t rnd_item();
    in_item_t r;
    if ($urandom_range(0, 9) < 8) begin
      r.whole_a = ($urandom_range(0, 3) == 0) ? 16'($urandom) : rnd_field($urandom_range(1, 2));
      r.whole_b = ($urandom_range(0, 3) == 0) ? 16'($urandom) : rnd_field($urandom_range(1, 2));
      r.numer_a = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 32767)) :
                  16'($urandom_range(0, 30));
      r.numer_b = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(0, 32767)) :
                  16'($urandom_range(0, 30));
      if (r.whole_a == 0 && $urandom_range(0, 1)) r.numer_a = -r.numer_a;
      if (r.whole_b == 0 && $urandom_range(0, 1)) r.numer_b = -r.numer_b;
      r.denom_a = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 32767)) :
                  16'($urandom_range(1, 40));
      r.denom_b = ($urandom_range(0, 2) == 0) ? 16'($urandom_range(1, 32767)) :
                  16'($urandom_range(1, 40));
    end else begin
      r = 96'({$urandom, $urandom, $urandom});
    end
    return r;
  endfunction

  initial begin
    logic [CFG_W-1:0] lens[6] = '{6'd32, 6'd2, 6'd63, 6'd1, 6'd5, 6'd20};
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send(mk(1, 1, 2, 2, 1, 3));
    send(mk(0, 0, 1, 0, 0, 1));
    send(mk(-3, 1, 4, 1, 0, 7));
    send(mk(0, -1, 3, 0, 0, 5));
    send(mk(2, 1, 0, 0, 0, 1));
    send(mk(0, 0, 1, 0, 1, -5));
    send(mk(2, -1, 3, 0, 0, 1));
    send(mk(32767, 32767, 1, 32767, 32767, 1));
    send(mk(-32768, 32767, 1, -32768, 32767, 1));
    send(mk(0, 1, 32767, 0, 1, 32766));
    send(mk(0, -32768, 32767, 0, -32768, 1));
    send(mk(-32768, -32768, -32768, 32767, 32767, 32767));
    send(mk(0, 1, 3, 0, 0, 1));
    gap();
    for (int ph = 0; ph < 6; ph++) begin
      write_len(lens[ph]);
      send(mk(0, 1, 7, -1, 0, 1));
      send(mk(12, 1, 3, 0, 0, 1));
      for (int i = 0; i < 57; i++) begin
        if (i == 30) drain();
        send(rnd_item());
        gap();
      end
    end
    write_len(LEN_RESET);
    for (int i = 0; i < 15; i++) begin
      send(rnd_item());
      gap();
    end
    drain();
    $display("%0d items sent, %0d characters checked over buffer lengths 1..63",
             items_sent, chars_seen);
    if (fail_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
